>>> src/bss_pkg.sv
`default_nettype none
package bss_pkg;

    typedef enum logic [3:0] {
        ACT_NOTE_ON        = 4'd0,
        ACT_PREPARE        = 4'd1,
        ACT_TRIGGER        = 4'd2,
        ACT_MOTION_REACHED = 4'd3,
        ACT_FINGER_PRESSED = 4'd4,
        ACT_SETTLED        = 4'd5,
        ACT_START_BOW      = 4'd6,
        ACT_NOTE_OFF       = 4'd7,
        ACT_BOW_RELEASED   = 4'd8,
        ACT_PANIC          = 4'd9,
        ACT_SET_SERVICE    = 4'd10
    } t_action;

    localparam logic [1:0] SVC_IDLE     = 2'd0;
    localparam logic [1:0] SVC_DISABLED = 2'd1;
    localparam logic [1:0] SVC_FAULT    = 2'd2;

    typedef enum logic [9:0] {
        PH_IDLE      = 10'b00_0000_0001,
        PH_RELEASING = 10'b00_0000_0010,
        PH_MOVING    = 10'b00_0000_0100,
        PH_PRESSING  = 10'b00_0000_1000,
        PH_SETTLING  = 10'b00_0001_0000,
        PH_READY     = 10'b00_0010_0000,
        PH_BOWING    = 10'b00_0100_0000,
        PH_REL_BOW   = 10'b00_1000_0000,
        PH_DISABLED  = 10'b01_0000_0000,
        PH_FAULT     = 10'b10_0000_0000
    } t_phase;

    localparam logic [3:0] PCODE_IDLE      = 4'd0;
    localparam logic [3:0] PCODE_RELEASING = 4'd1;
    localparam logic [3:0] PCODE_MOVING    = 4'd2;
    localparam logic [3:0] PCODE_PRESSING  = 4'd3;
    localparam logic [3:0] PCODE_SETTLING  = 4'd4;
    localparam logic [3:0] PCODE_READY     = 4'd5;
    localparam logic [3:0] PCODE_BOWING    = 4'd6;
    localparam logic [3:0] PCODE_REL_BOW   = 4'd7;
    localparam logic [3:0] PCODE_DISABLED  = 4'd8;
    localparam logic [3:0] PCODE_FAULT     = 4'd9;

    localparam logic [15:0] ID_NONE  = 16'd0;
    localparam logic [15:0] ID_FIRST = 16'd1;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] current_id;
        logic [15:0] next_id;
        logic [4:0]  fret_target;
        logic        open_flag;
        logic        armed_flag;
        logic        arm_when_settled;
    } t_str_state;

    typedef struct packed {
        logic        accepted;
        logic [15:0] issued_id;
        logic [3:0]  phase;
        logic        bow_armed;
        logic        trigger_pulse;
        logic [4:0]  target_fret;
    } t_result;

    function automatic logic [3:0] phase_code(input t_phase ph);
        logic [3:0] code;
        case (ph)
            PH_IDLE:      code = PCODE_IDLE;
            PH_RELEASING: code = PCODE_RELEASING;
            PH_MOVING:    code = PCODE_MOVING;
            PH_PRESSING:  code = PCODE_PRESSING;
            PH_SETTLING:  code = PCODE_SETTLING;
            PH_READY:     code = PCODE_READY;
            PH_BOWING:    code = PCODE_BOWING;
            PH_REL_BOW:   code = PCODE_REL_BOW;
            PH_DISABLED:  code = PCODE_DISABLED;
            PH_FAULT:     code = PCODE_FAULT;
            default:      code = PCODE_IDLE;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

>>> src/bss_evt_if.sv
`default_nettype none
interface bss_evt_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [4:0]  fret;
    logic [15:0] command_id;
    logic [1:0]  service_code;

    modport source (output valid, output action, output fret, output command_id,
                    output service_code, input ready);
    modport sink   (input valid, input action, input fret, input command_id,
                    input service_code, output ready);
endinterface
`default_nettype wire

>>> src/bss_res_if.sv
`default_nettype none
interface bss_res_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [15:0] issued_id;
    logic [3:0]  phase;
    logic        bow_armed;
    logic        trigger_pulse;
    logic [4:0]  target_fret;

    modport source (output valid, output accepted, output issued_id, output phase,
                    output bow_armed, output trigger_pulse, output target_fret,
                    input ready);
    modport sink   (input valid, input accepted, input issued_id, input phase,
                    input bow_armed, input trigger_pulse, input target_fret,
                    output ready);
endinterface
`default_nettype wire

>>> src/bss_step.sv
`default_nettype none
module bss_step
    import bss_pkg::*;
(
    input  t_str_state  i_state,
    input  logic [3:0]  i_action,
    input  logic [4:0]  i_fret,
    input  logic [15:0] i_command_id,
    input  logic [1:0]  i_service_code,
    output t_str_state  o_state,
    output t_result     o_result
);

    logic        out_of_service;
    logic        id_match;
    logic [15:0] bumped_id;
    logic        acc;
    logic        pulse;
    logic [15:0] issued;
    t_str_state  st;

    assign out_of_service = (i_state.phase == PH_DISABLED) || (i_state.phase == PH_FAULT);
    assign id_match       = (i_command_id != ID_NONE) && (i_command_id == i_state.current_id);
    assign bumped_id      = i_state.next_id + 16'd1;

    always_comb begin
        st     = i_state;
        acc    = 1'b0;
        pulse  = 1'b0;
        issued = ID_NONE;
        case (t_action'(i_action))
            ACT_NOTE_ON, ACT_PREPARE: begin
                if (!out_of_service) begin
                    st.current_id       = i_state.next_id;
                    // skip id zero on wrap
                    st.next_id          = (bumped_id == ID_NONE) ? ID_FIRST : bumped_id;
                    st.fret_target      = i_fret;
                    st.open_flag        = (i_fret == 5'd0);
                    st.armed_flag       = 1'b0;
                    st.arm_when_settled = (t_action'(i_action) == ACT_NOTE_ON);
                    st.phase            = PH_RELEASING;
                    issued              = i_state.next_id;
                    acc                 = 1'b1;
                end
            end
            ACT_TRIGGER: begin
                if (id_match && !out_of_service) begin
                    st.arm_when_settled = 1'b1;
                    if (i_state.phase == PH_READY) begin
                        st.armed_flag = 1'b1;
                    end
                    pulse = 1'b1;
                    acc   = 1'b1;
                end
            end
            ACT_MOTION_REACHED: begin
                if (i_state.phase == PH_RELEASING || i_state.phase == PH_MOVING) begin
                    if (i_state.open_flag) begin
                        st.phase      = PH_READY;
                        st.armed_flag = i_state.arm_when_settled;
                    end else begin
                        st.phase = PH_PRESSING;
                    end
                    acc = 1'b1;
                end
            end
            ACT_FINGER_PRESSED: begin
                if (i_state.phase == PH_PRESSING) begin
                    st.phase = PH_SETTLING;
                    acc      = 1'b1;
                end
            end
            ACT_SETTLED: begin
                if (i_state.phase == PH_SETTLING) begin
                    st.phase      = PH_READY;
                    st.armed_flag = i_state.arm_when_settled;
                    acc           = 1'b1;
                end
            end
            ACT_START_BOW: begin
                if (id_match && i_state.phase == PH_READY && i_state.armed_flag) begin
                    st.armed_flag = 1'b0;
                    st.phase      = PH_BOWING;
                    acc           = 1'b1;
                end
            end
            ACT_NOTE_OFF: begin
                if (!out_of_service) begin
                    st.armed_flag       = 1'b0;
                    st.arm_when_settled = 1'b0;
                    st.current_id       = ID_NONE;
                    st.phase = (i_state.phase == PH_BOWING) ? PH_REL_BOW : PH_IDLE;
                    acc      = 1'b1;
                end
            end
            ACT_BOW_RELEASED: begin
                if (i_state.phase == PH_REL_BOW) begin
                    st.phase = PH_IDLE;
                    acc      = 1'b1;
                end
            end
            ACT_PANIC: begin
                st.armed_flag       = 1'b0;
                st.arm_when_settled = 1'b0;
                st.current_id       = ID_NONE;
                // keep an out-of-service phase
                if (!out_of_service) begin
                    st.phase = PH_IDLE;
                end
                acc = 1'b1;
            end
            ACT_SET_SERVICE: begin
                if (i_service_code == SVC_IDLE || i_service_code == SVC_DISABLED ||
                    i_service_code == SVC_FAULT) begin
                    st.armed_flag       = 1'b0;
                    st.arm_when_settled = 1'b0;
                    st.current_id       = ID_NONE;
                    case (i_service_code)
                        SVC_DISABLED: st.phase = PH_DISABLED;
                        SVC_FAULT:    st.phase = PH_FAULT;
                        default:      st.phase = PH_IDLE;
                    endcase
                    acc = 1'b1;
                end
            end
            default: begin
                acc = 1'b0;
            end
        endcase
    end

    assign o_state                = st;
    assign o_result.accepted      = acc;
    assign o_result.issued_id     = issued;
    assign o_result.phase         = phase_code(st.phase);
    assign o_result.bow_armed     = st.armed_flag;
    assign o_result.trigger_pulse = pulse;
    assign o_result.target_fret   = st.fret_target;

endmodule
`default_nettype wire

>>> src/bowed_string_note_sequencer.sv
// Channel   Dir  Modport  Beat contents
// i_evt     in   sink     action, fret, command_id, service_code
// o_res     out  source   accepted, issued_id, phase, bow_armed, trigger_pulse, target_fret
//
// One event per cycle while o_res is not stalled: the string state and the result register
// load on the same edge that takes the event beat, and the result shows in the cycle after.
// The result is held in a single result register.
// i_evt.ready is high while the result register is empty or being drained this cycle.
// A stall on o_res holds the result and blocks new events; nothing is dropped.
// Synchronous active-low reset: phase idle, ids cleared, next id one, no result pending.
`default_nettype none
module bowed_string_note_sequencer
    import bss_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    bss_evt_if.sink    i_evt,
    bss_res_if.source  o_res
);

    t_str_state r_state;
    t_str_state n_state;
    t_result    r_res;
    t_result    n_res;
    logic       r_out_valid;
    logic       evt_take;

    assign i_evt.ready = !r_out_valid || o_res.ready;
    assign evt_take    = i_evt.valid && i_evt.ready;

    bss_step u_step (
        .i_state        (r_state),
        .i_action       (i_evt.action),
        .i_fret         (i_evt.fret),
        .i_command_id   (i_evt.command_id),
        .i_service_code (i_evt.service_code),
        .o_state        (n_state),
        .o_result       (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase            <= PH_IDLE;
            r_state.current_id       <= ID_NONE;
            r_state.next_id          <= ID_FIRST;
            r_state.fret_target      <= 5'd0;
            r_state.open_flag        <= 1'b0;
            r_state.armed_flag       <= 1'b0;
            r_state.arm_when_settled <= 1'b0;
            r_out_valid              <= 1'b0;
        end else begin
            if (evt_take) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (evt_take) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.accepted      = r_res.accepted;
    assign o_res.issued_id     = r_res.issued_id;
    assign o_res.phase         = r_res.phase;
    assign o_res.bow_armed     = r_res.bow_armed;
    assign o_res.trigger_pulse = r_res.trigger_pulse;
    assign o_res.target_fret   = r_res.target_fret;

`ifndef SYNTH
    a_next_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.next_id != ID_NONE)
        else $error("next id reached zero");

    a_armed_only_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.armed_flag |-> r_state.phase == PH_READY)
        else $error("bow armed outside ready phase");

    a_issue_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.issued_id != ID_NONE || r_res.trigger_pulse))
            |-> r_res.accepted)
        else $error("id issued or trigger pulsed on a refused event");

    a_take_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        evt_take |=> r_out_valid && r_res.phase == phase_code(r_state.phase))
        else $error("result phase disagrees with state");
`endif

endmodule
`default_nettype wire

>>> dv/bss_tb_pkg.sv
package bss_tb_pkg;
    import bss_pkg::*;

    localparam logic [1:0] SVC_UNUSED       = 2'd3;
    localparam logic [3:0] ACT_CODE_MAX     = 4'hF;
    localparam int         SHOWN_MISMATCHES = 10;

    class string_tracker;
        logic [3:0]  ph;
        logic [15:0] live_id;
        logic [15:0] next_free;
        logic [4:0]  fret_goal;
        logic        open_str;
        logic        armed;
        logic        arm_on_settle;
        t_result     pending_results[$];
        int          mismatches;
        int          failures;

        function new();
            ph            = PCODE_IDLE;
            live_id       = ID_NONE;
            next_free     = ID_FIRST;
            fret_goal     = '0;
            open_str      = 1'b0;
            armed         = 1'b0;
            arm_on_settle = 1'b0;
            mismatches    = 0;
            failures      = 0;
        endfunction

        function bit out_of_service();
            return ph == PCODE_DISABLED || ph == PCODE_FAULT;
        endfunction

        function void drop_command();
            armed         = 1'b0;
            arm_on_settle = 1'b0;
            live_id       = ID_NONE;
        endfunction

        function bit id_ok(logic [15:0] id);
            return id != ID_NONE && id == live_id;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Apply one event to the string state and build the result it produces.
        function t_result advance_string(logic [3:0] act, logic [4:0] fr,
                                         logic [15:0] id, logic [1:0] code);
            t_result r;
            bit      sounding;
            r = '0;
            case (act)
                ACT_NOTE_ON, ACT_PREPARE: begin
                    if (!out_of_service()) begin
                        live_id   = next_free;
                        next_free = next_free + 16'd1;
                        // zero is never issued
                        if (next_free == ID_NONE)
                            next_free = ID_FIRST;
                        fret_goal     = fr;
                        open_str      = (fr == '0);
                        armed         = 1'b0;
                        arm_on_settle = (act == ACT_NOTE_ON);
                        ph            = PCODE_RELEASING;
                        r.issued_id   = live_id;
                        r.accepted    = 1'b1;
                    end
                end
                ACT_TRIGGER: begin
                    if (id_ok(id) && !out_of_service()) begin
                        arm_on_settle   = 1'b1;
                        r.trigger_pulse = 1'b1;
                        if (ph == PCODE_READY)
                            armed = 1'b1;
                        r.accepted = 1'b1;
                    end
                end
                ACT_MOTION_REACHED: begin
                    if (ph == PCODE_RELEASING || ph == PCODE_MOVING) begin
                        if (open_str) begin
                            ph    = PCODE_READY;
                            armed = arm_on_settle;
                        end else begin
                            ph = PCODE_PRESSING;
                        end
                        r.accepted = 1'b1;
                    end
                end
                ACT_FINGER_PRESSED: begin
                    if (ph == PCODE_PRESSING) begin
                        ph         = PCODE_SETTLING;
                        r.accepted = 1'b1;
                    end
                end
                ACT_SETTLED: begin
                    if (ph == PCODE_SETTLING) begin
                        ph         = PCODE_READY;
                        armed      = arm_on_settle;
                        r.accepted = 1'b1;
                    end
                end
                ACT_START_BOW: begin
                    if (id_ok(id) && ph == PCODE_READY && armed) begin
                        armed      = 1'b0;
                        ph         = PCODE_BOWING;
                        r.accepted = 1'b1;
                    end
                end
                ACT_NOTE_OFF: begin
                    if (!out_of_service()) begin
                        sounding = (ph == PCODE_BOWING);
                        drop_command();
                        ph         = sounding ? PCODE_REL_BOW : PCODE_IDLE;
                        r.accepted = 1'b1;
                    end
                end
                ACT_BOW_RELEASED: begin
                    if (ph == PCODE_REL_BOW) begin
                        ph         = PCODE_IDLE;
                        r.accepted = 1'b1;
                    end
                end
                ACT_PANIC: begin
                    drop_command();
                    if (!out_of_service())
                        ph = PCODE_IDLE;
                    r.accepted = 1'b1;
                end
                ACT_SET_SERVICE: begin
                    if (code != SVC_UNUSED) begin
                        drop_command();
                        ph = (code == SVC_IDLE)     ? PCODE_IDLE :
                             (code == SVC_DISABLED) ? PCODE_DISABLED : PCODE_FAULT;
                        r.accepted = 1'b1;
                    end
                end
                default: ;
            endcase
            r.phase       = ph;
            r.bow_armed   = armed;
            r.target_fret = fret_goal;
            return r;
        endfunction

        function void take_event(logic [3:0] act, logic [4:0] fr,
                                 logic [15:0] id, logic [1:0] code);
            pending_results.push_back(advance_string(act, fr, id, code));
        endfunction

        function void note_mismatch(string what, t_result want, t_result got);
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES) begin
                $display("%s: expected acc=%0b id=%0h ph=%0d arm=%0b pulse=%0b fret=%0d",
                         what, want.accepted, want.issued_id, want.phase,
                         want.bow_armed, want.trigger_pulse, want.target_fret);
                $display("    actual acc=%0b id=%0h ph=%0d arm=%0b pulse=%0b fret=%0d",
                         got.accepted, got.issued_id, got.phase,
                         got.bow_armed, got.trigger_pulse, got.target_fret);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                failures++;
                note_mismatch("result with no event behind it", '0, got);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                failures++;
                note_mismatch("result mismatch", want, got);
            end
        endfunction

        function void close_out();
            if (pending_results.size() != 0) begin
                failures += pending_results.size();
                $display("%0d expected results never arrived", pending_results.size());
            end
        endfunction
    endclass

endpackage

>>> dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bss_pkg::*;
    import bss_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS  = 132;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bss_evt_if evt();
    bss_res_if res();

    bowed_string_note_sequencer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt),
        .o_res   (res)
    );

    string_tracker tracker;
    t_result       seen;
    int            src_idle_pct;
    int            sink_stall_pct;
    int            items_sent;
    int            cycles;
    int            target;

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        res.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            seen.accepted      = res.accepted;
            seen.issued_id     = res.issued_id;
            seen.phase         = res.phase;
            seen.bow_armed     = res.bow_armed;
            seen.trigger_pulse = res.trigger_pulse;
            seen.target_fret   = res.target_fret;
            tracker.check_result(seen);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("bowed_string_note_sequencer verification failed");
            $finish;
        end
    end

    // Offer one beat, idling first at the current rate, and log it once taken.
    task automatic send_event(input logic [3:0] act, input logic [4:0] fr,
                              input logic [15:0] id, input logic [1:0] code);
        while ($urandom_range(99) < src_idle_pct) begin
            evt.valid <= 1'b0;
            @(posedge i_clk);
        end
        evt.valid        <= 1'b1;
        evt.action       <= act;
        evt.fret         <= fr;
        evt.command_id   <= id;
        evt.service_code <= code;
        do
            @(posedge i_clk);
        while (evt.ready !== 1'b1);
        tracker.take_event(act, fr, id, code);
        items_sent++;
    endtask

    task automatic send_noise();
        send_event(4'($urandom_range(ACT_CODE_MAX)), 5'($urandom), 16'($urandom),
                   2'($urandom));
    endtask

    // One step of a note, sometimes preceded by noise or carrying a stale id.
    task automatic note_step(input logic [3:0] act, input logic [15:0] id);
        logic [15:0] use_id;
        use_id = id;
        if ($urandom_range(99) < 10)
            send_noise();
        if ($urandom_range(99) < 8)
            use_id = $urandom_range(1) ? ID_NONE : (id ^ 16'($urandom_range(65535, 1)));
        send_event(act, 5'($urandom), use_id, 2'($urandom));
    endtask

    task automatic play_note();
        logic [4:0]  fr;
        logic [15:0] id;
        bit          direct;
        bit          triggered;
        fr        = ($urandom_range(3) == 0) ? 5'd0 : 5'($urandom);
        direct    = $urandom_range(1);
        triggered = 1'b0;
        send_event(direct ? ACT_NOTE_ON : ACT_PREPARE, fr, 16'($urandom), 2'($urandom));
        id = tracker.live_id;
        if (!direct && $urandom_range(1)) begin
            note_step(ACT_TRIGGER, id);
            triggered = 1'b1;
        end
        note_step(ACT_MOTION_REACHED, id);
        if (fr != '0) begin
            note_step(ACT_FINGER_PRESSED, id);
            note_step(ACT_SETTLED, id);
        end
        if (!direct && !triggered)
            note_step(ACT_TRIGGER, id);
        note_step(ACT_START_BOW, id);
        note_step(ACT_NOTE_OFF, id);
        note_step(ACT_BOW_RELEASED, id);
    endtask

    task automatic random_traffic();
        if (tracker.out_of_service() && $urandom_range(9) < 7)
            send_event(ACT_SET_SERVICE, 5'($urandom), 16'($urandom), SVC_IDLE);
        else if ($urandom_range(3) == 0)
            send_noise();
        else
            play_note();
    endtask

    task automatic wait_drained();
        evt.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_event(ACT_BOW_RELEASED, '1, '1, '1);
        send_event(ACT_NOTE_ON, 5'd31, ID_NONE, SVC_IDLE);
        send_event(ACT_TRIGGER, '0, ID_NONE, SVC_IDLE);
        send_event(ACT_TRIGGER, '0, 16'hFFFF, SVC_IDLE);
        send_event(ACT_MOTION_REACHED, '0, '0, '0);
        send_event(ACT_MOTION_REACHED, '0, '0, '0);
        send_event(ACT_FINGER_PRESSED, '0, '0, '0);
        send_event(ACT_SETTLED, '0, '0, '0);
        send_event(ACT_START_BOW, '0, tracker.live_id, '0);
        send_event(ACT_NOTE_OFF, '0, '0, '0);
        send_event(ACT_BOW_RELEASED, '0, '0, '0);
        // open string skips the finger steps
        send_event(ACT_PREPARE, 5'd0, '1, '1);
        send_event(ACT_MOTION_REACHED, '0, '0, '0);
        send_event(ACT_START_BOW, '0, tracker.live_id, '0);
        send_event(ACT_TRIGGER, '0, tracker.live_id, '0);
        send_event(ACT_START_BOW, '0, ID_NONE, '0);
        send_event(ACT_START_BOW, '0, tracker.live_id, '0);
        send_event(ACT_PANIC, '0, '0, '0);
        send_event(ACT_SET_SERVICE, '0, '0, SVC_DISABLED);
        send_event(ACT_NOTE_ON, 5'd5, '0, '0);
        send_event(ACT_NOTE_OFF, '0, '0, '0);
        send_event(ACT_PANIC, '0, '0, '0);
        send_event(ACT_SET_SERVICE, '0, '0, SVC_UNUSED);
        send_event(ACT_SET_SERVICE, '0, '0, SVC_FAULT);
        send_event(ACT_PREPARE, 5'd9, '0, '0);
        send_event(ACT_SET_SERVICE, '0, '0, SVC_IDLE);
        send_event(ACT_CODE_MAX, '1, '1, '1);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        target         = items_sent + PHASE_ITEMS;
        while (items_sent < target)
            random_traffic();
    endtask

    initial begin
        tracker            = new();
        cycles             = 0;
        items_sent         = 0;
        src_idle_pct       = 0;
        sink_stall_pct     = 0;
        i_rst_n            = 1'b0;
        evt.valid          = 1'b0;
        evt.action         = ACT_PANIC;
        evt.fret           = '0;
        evt.command_id     = ID_NONE;
        evt.service_code   = SVC_IDLE;
        res.ready          = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_phase(0, 0);
        run_phase(84, 0);
        // hold the sender until the block has emptied out
        wait_drained();
        run_phase(0, 84);
        run_phase(35, 35);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        tracker.close_out();
        if (tracker.failures == 0)
            $display("bowed_string_note_sequencer verification clean");
        else
            $display("bowed_string_note_sequencer verification failed");
        $finish;
    end

endmodule
